// ----- hw/rtl/ilid_pkg.sv -----
// shared types and constants for the indexed list insert/delete unit
package ilid_pkg;

   localparam int CAPACITY = 32;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 6;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_DATA_W = ((KIND_W + POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + STAT_W + LEN_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_GET    = 3'd0,
      KIND_FRONT  = 3'd1,
      KIND_BACK   = 3'd2,
      KIND_INSERT = 3'd3,
      KIND_DELETE = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic             ins;
      logic             del;
      logic [CMP_W-1:0] pos;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- hw/rtl/indexed_list_insert_delete_unit.sv -----
// top level: request decode, count register, row of entry cells and result register
// latency: a result appears in the cycle after its request transfer
// throughput: one request per cycle while results are taken, each applied by the cell row
// a waiting result does not block the next request when the result is taken in that cycle
// reset clears the entry count and the result valid; entry cells are not cleared
module indexed_list_insert_delete_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // kind [2:0], position [8:3], value [40:9], zero pad above
   input  logic [ilid_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value [31:0], status [33:32], length [39:34]
   output logic [ilid_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ilid_pkg::*;

   logic [KIND_W-1:0]  req_kind;
   logic [POS_W-1:0]   req_pos;
   logic [VAL_W-1:0]   req_value;
   logic               accept;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   count_next_ext;
   logic               full;
   logic               ins;
   logic               del;
   logic [CMP_W-1:0]   eff_pos;
   status_type         status;
   logic [VAL_W-1:0]   read_value;
   cell_cmd_type       cmd;

   logic [VAL_W-1:0]   cell_data [CAPACITY];

   assign req_kind  = req_tdata[KIND_W-1:0];
   assign req_pos   = req_tdata[KIND_W+POS_W-1:KIND_W];
   assign req_value = req_tdata[KIND_W+POS_W+VAL_W-1:KIND_W+POS_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos_ext   = CMP_W'(req_pos);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ext == CMP_W'(CAPACITY));

   always_comb begin
      ins        = 1'b0;
      del        = 1'b0;
      eff_pos    = pos_ext;
      status     = ST_DONE;
      read_value = '1;
      unique case (req_kind)
         KIND_GET: begin
            if (pos_ext < count_ext) begin
               read_value = cell_data[pos_ext[IDX_W-1:0]];
            end else begin
               status = ST_RANGE;
            end
         end
         KIND_FRONT: begin
            eff_pos = '0;
            if (full) status = ST_FULL;
            else      ins    = 1'b1;
         end
         KIND_BACK: begin
            eff_pos = count_ext;
            if (full) status = ST_FULL;
            else      ins    = 1'b1;
         end
         KIND_INSERT: begin
            if (pos_ext > count_ext) status = ST_RANGE;
            else if (full)           status = ST_FULL;
            else                     ins    = 1'b1;
         end
         KIND_DELETE: begin
            if (pos_ext >= count_ext) status = ST_RANGE;
            else                      del    = 1'b1;
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   assign cmd.ins   = accept && ins;
   assign cmd.del   = accept && del;
   assign cmd.pos   = eff_pos;
   assign cmd.value = req_value;

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (cmd.del) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   assign count_next_ext = CMP_W'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({count_next_ext[LEN_W-1:0], status, read_value});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] left_data;
      logic [VAL_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      ilid_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

endmodule

// ----- hw/rtl/ilid_cell.sv -----
// one entry cell of the shifting row
module ilid_cell (
   input  logic                        clock,
   input  logic [ilid_pkg::IDX_W-1:0]  index,
   input  ilid_pkg::cell_cmd_type      cmd,
   input  logic [ilid_pkg::VAL_W-1:0]  left_data,
   input  logic [ilid_pkg::VAL_W-1:0]  right_data,
   output logic [ilid_pkg::VAL_W-1:0]  data
);
   import ilid_pkg::*;

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;
   logic [CMP_W-1:0] index_ext;

   assign index_ext = CMP_W'(index);

   always_comb begin
      data_in = data_ff;
      priority if (cmd.ins) begin
         if (index_ext > cmd.pos) begin
            data_in = left_data;
         end else if (index_ext == cmd.pos) begin
            data_in = cmd.value;
         end
      end else if (cmd.del) begin
         if (index_ext >= cmd.pos) begin
            data_in = right_data;
         end
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- hw/rtl/ilid_checker.sv -----
// port-level checks for the indexed list insert/delete unit, with bind
module ilid_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ilid_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ilid_pkg::*;

   logic [VAL_W-1:0]  rsp_value;
   logic [STAT_W-1:0] rsp_status;
   logic [LEN_W-1:0]  rsp_length;

   assign rsp_value  = rsp_tdata[VAL_W-1:0];
   assign rsp_status = rsp_tdata[VAL_W+STAT_W-1:VAL_W];
   assign rsp_length = rsp_tdata[VAL_W+STAT_W+LEN_W-1:VAL_W+STAT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transfer without a result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != ST_DONE |-> rsp_value == '1)
      else $error("failed request returned a value");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> LEN_W'(CAPACITY) == '0 || rsp_length <= LEN_W'(CAPACITY))
      else $error("length above capacity");

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (.*);

// ----- tb/indexed_list_insert_delete_unit_test.sv -----
// self-checking testbench for the indexed list insert/delete unit
`timescale 1ns / 100ps

module indexed_list_insert_delete_unit_test;
   import ilid_pkg::*;

   localparam logic [KIND_W-1:0] KIND_RESERVED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RESERVED_LAST  = 3'd7;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 4;

   typedef struct {
      logic [VAL_W-1:0] read_value;
      status_type       status;
      logic [LEN_W-1:0] length;
   } list_rsp_type;

   class list_mirror;
      logic [VAL_W-1:0] cells [CAPACITY];
      int unsigned      fill;
      list_rsp_type     awaited [$];
      int               errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function void insert_at(int unsigned p, logic [VAL_W-1:0] v);
         for (int unsigned i = fill; i > p; i--)
            cells[i] = cells[i - 1];
         cells[p] = v;
         fill++;
      endfunction

      // mirror one request transfer and queue the result it must produce
      function void apply_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                                  logic [VAL_W-1:0] v);
         list_rsp_type r;
         r.read_value = '1;
         r.status     = ST_DONE;
         case (k)
            KIND_GET: begin
               if (p < fill) r.read_value = cells[p];
               else r.status = ST_RANGE;
            end
            KIND_FRONT, KIND_BACK: begin
               if (fill >= CAPACITY) r.status = ST_FULL;
               else insert_at((k == KIND_FRONT) ? 0 : fill, v);
            end
            KIND_INSERT: begin
               if (p > fill) r.status = ST_RANGE;
               else if (fill >= CAPACITY) r.status = ST_FULL;
               else insert_at(p, v);
            end
            KIND_DELETE: begin
               if (p >= fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (int unsigned i = p; i + 1 < fill; i++)
                     cells[i] = cells[i + 1];
                  fill--;
               end
            end
            default: r.status = ST_RANGE;
         endcase
         r.length = LEN_W'(fill);
         awaited.push_back(r);
      endfunction

      function void compare_response(logic [RSP_DATA_W-1:0] d);
         list_rsp_type     e;
         logic [VAL_W-1:0] got_value;
         logic [STAT_W-1:0] got_status;
         logic [LEN_W-1:0] got_length;
         got_value  = d[VAL_W-1:0];
         got_status = d[VAL_W +: STAT_W];
         got_length = d[VAL_W + STAT_W +: LEN_W];
         if (awaited.size() == 0) begin
            $error("unexpected result transfer: data %h", d);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (got_value !== e.read_value) begin
            $error("read_value: expected %h, actual %h", e.read_value, got_value);
            errors++;
         end
         if (got_status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got_status);
            errors++;
         end
         if (got_length !== e.length) begin
            $error("length: expected %0d, actual %0d", e.length, got_length);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   list_mirror mirror = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  quiet_cycles  = 0;
   bit  growing       = 1'b1;

   indexed_list_insert_delete_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   task automatic push_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                               logic [VAL_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - KIND_W - POS_W - VAL_W){1'b0}}, v, p, k};
      do @(posedge clock); while (!req_tready);
      mirror.apply_request(k, p, v);
   endtask

   // grow toward full, linger there, then shrink toward empty
   task automatic random_requests(int n);
      logic [KIND_W-1:0] k;
      logic [POS_W-1:0]  p;
      logic [VAL_W-1:0]  v;
      int                r;
      for (int i = 0; i < n; i++) begin
         if (mirror.fill == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
         else if (mirror.fill == 0) growing = 1'b1;
         r = $urandom_range(99);
         if (r < 3) begin
            k = KIND_W'($urandom_range(KIND_RESERVED_LAST, KIND_RESERVED_FIRST));
         end else if (r < 23) begin
            k = KIND_GET;
         end else if ($urandom_range(99) < (growing ? 70 : 25)) begin
            case ($urandom_range(2))
               0: k = KIND_FRONT;
               1: k = KIND_BACK;
               default: k = KIND_INSERT;
            endcase
         end else begin
            k = KIND_DELETE;
         end
         if ($urandom_range(9) == 0) p = POS_W'($urandom_range(63));
         else p = POS_W'($urandom_range(mirror.fill));
         case ($urandom_range(15))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = '1;
            3: v = '0;
            default: v = $urandom();
         endcase
         push_request(k, p, v);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 74;
      push_request(KIND_GET,    6'd0,  32'h1234_5678);
      push_request(KIND_DELETE, 6'd0,  32'h0);
      push_request(KIND_INSERT, 6'd1,  32'h5555_5555);
      push_request(KIND_INSERT, 6'd0,  32'h7fff_ffff);
      push_request(KIND_FRONT,  6'd63, 32'h8000_0000);
      push_request(KIND_BACK,   6'd0,  32'hffff_ffff);
      push_request(KIND_INSERT, 6'd3,  32'h0);
      push_request(KIND_INSERT, 6'd2,  32'h1234_5678);
      for (int i = 0; i < 5; i++)
         push_request(KIND_GET, POS_W'(i), 32'h0);
      push_request(KIND_GET,    6'd63, 32'h0);
      push_request(KIND_DELETE, 6'd63, 32'h0);
      push_request(KIND_INSERT, 6'd63, 32'haaaa_aaaa);
      push_request(KIND_DELETE, 6'd4,  32'h0);
      push_request(KIND_DELETE, 6'd0,  32'h0);
      push_request(KIND_DELETE, 6'd1,  32'h0);
      for (int k = KIND_RESERVED_FIRST; k <= KIND_RESERVED_LAST; k++)
         push_request(KIND_W'(k), 6'd63, 32'hffff_ffff);
      push_request(KIND_GET,    6'd0,  32'h0);

      random_requests(250);
      send_idle_pct = 74;
      recv_idle_pct = 34;
      random_requests(270);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(260);

      req_tvalid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.errors == 0) $display("indexed_list_insert_delete_unit_test passed");
      else $display("indexed_list_insert_delete_unit_test failed");
      $finish;
   end

   // result side: random backpressure, check every result transfer
   initial begin
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) mirror.compare_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("indexed_list_insert_delete_unit_test failed");
         $finish;
      end
   end

endmodule

// ----- files.f -----
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_cell.sv
hw/rtl/indexed_list_insert_delete_unit.sv
hw/rtl/ilid_checker.sv
tb/indexed_list_insert_delete_unit_test.sv
